@@ rtl/psbi_pkg.sv @@
// Shared constants, codes, entry type and state encoding for the priority stack.
package psbi_pkg;

  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned PAYLOAD_BITS = 32;
  localparam int unsigned PRIO_BITS    = 16;

  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH      = 2'd0,
    MODE_PRIO_PUSH = 2'd1,
    MODE_POP       = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0]     payload;
    logic signed [PRIO_BITS-1:0] prio;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_POP    = 4'b0010,
    ST_BUBBLE = 4'b0100,
    ST_LAST   = 4'b1000
  } state_e;

endpackage

@@ rtl/psbi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module psbi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/psbi_swap_unit.sv @@
// Compare-and-select step of the bubble pass.
module psbi_swap_unit (
  input  psbi_pkg::entry_t upper_i,
  input  psbi_pkg::entry_t lower_i,
  output psbi_pkg::entry_t keep_o,
  output psbi_pkg::entry_t place_o
);
  import psbi_pkg::*;

  logic swap;

  // upper strictly greater sinks; ties stay put
  assign swap    = $signed(upper_i.prio) > $signed(lower_i.prio);
  assign keep_o  = swap ? upper_i : lower_i;
  assign place_o = swap ? lower_i : upper_i;

endmodule

@@ rtl/priority_stack_bubble_insert_core.sv @@
// Priority stack: push, priority push with one bubble pass, pop.
//
// Bounded stack of payload/priority words held in one RAM. Plain push, pop on
// an empty stack, a dropped push on a full stack, a priority push onto an
// empty stack and the unused mode are handled without leaving ST_IDLE; a pop
// passes through ST_POP for the registered RAM read. A priority push onto a
// non-empty stack runs a bubble pass in ST_BUBBLE and ST_LAST: the pass
// walks the stack top to bottom one entry per cycle through the single RAM
// read port and one compare/select unit, carrying the sinking word in a
// register, then writes the carried word to the bottom. The result word of a
// push is issued at acceptance and may wait in the output register while the
// pass runs; no new word is taken until the walk has finished.
module priority_stack_bubble_insert_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [31:0]        payload_i,
  input  logic signed [15:0] priority_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        popped_payload_o,
  output logic [1:0]         status_o,
  output logic [4:0]         fill_level_o
);
  import psbi_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  entry_t             carry_q, carry_d;

  logic               out_valid_q, out_valid_d;
  logic [31:0]        popped_q, popped_d;
  status_e            status_q, status_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               out_load;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  entry_t             ram_wdata, ram_rdata;
  entry_t             keep, place;

  logic               accept, full, empty;
  logic [ADDR_W-1:0]  top_addr;
  entry_t             new_entry;

  psbi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  psbi_swap_unit u_swap (
    .upper_i (carry_q),
    .lower_i (ram_rdata),
    .keep_o  (keep),
    .place_o (place)
  );

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = count_q >= CNT_W'(STACK_DEPTH);
  assign empty      = count_q == '0;
  assign top_addr   = ADDR_W'(count_q);

  assign new_entry.payload = PAYLOAD_BITS'(payload_i);
  assign new_entry.prio    = (mode_i == MODE_PRIO_PUSH) ? priority_req_i : '0;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    carry_d   = carry_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = carry_q;
    ram_raddr = idx_q - ADDR_W'(1);
    out_load  = 1'b0;
    popped_d  = popped_q;
    status_d  = status_q;
    fill_d    = fill_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          popped_d = '0;
          status_d = STATUS_DONE;
          case (mode_i)
            MODE_PUSH, MODE_PRIO_PUSH: begin
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                count_d = count_q + CNT_W'(1);
                if (mode_i == MODE_PUSH || empty) begin
                  ram_we    = 1'b1;
                  ram_waddr = top_addr;
                  ram_wdata = new_entry;
                end else begin
                  // new word is carried down from the top slot
                  carry_d   = new_entry;
                  idx_d     = top_addr;
                  ram_raddr = top_addr - ADDR_W'(1);
                  state_d   = ST_BUBBLE;
                end
              end
            end
            MODE_POP: begin
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                out_load  = 1'b0;
                count_d   = count_q - CNT_W'(1);
                ram_raddr = top_addr - ADDR_W'(1);
                state_d   = ST_POP;
              end
            end
            default: begin
            end
          endcase
          fill_d = count_d;
        end
      end
      ST_POP: begin
        out_load = 1'b1;
        popped_d = 32'(ram_rdata.payload);
        status_d = STATUS_DONE;
        fill_d   = count_q;
        state_d  = ST_IDLE;
      end
      ST_BUBBLE: begin
        // ram_rdata holds entry idx-1; settle slot idx, keep the sinking word
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = place;
        carry_d   = keep;
        if (idx_q == ADDR_W'(1)) begin
          state_d = ST_LAST;
        end else begin
          ram_raddr = idx_q - ADDR_W'(2);
          idx_d     = idx_q - ADDR_W'(1);
        end
      end
      ST_LAST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = carry_q;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    carry_q <= carry_d;
    if (out_load) begin
      popped_q <= popped_d;
      status_q <= status_d;
      fill_q   <= fill_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign popped_payload_o = popped_q;
  assign status_o         = status_q;
  assign fill_level_o     = 5'(fill_q);

endmodule
